// ----- rtl/cte_pkg.sv -----
// Shared definitions for the counting trie engine: operation and status codes,
// default sizes and the command type of the shared count unit.
// No dependencies.
package cte_pkg;

    localparam int CTE_NODE_COUNT    = 4096;
    localparam int CTE_ALPHABET_SIZE = 26;
    localparam int CTE_COUNT_BITS    = 16;

    localparam logic [1:0] OP_INSERT       = 2'd0;
    localparam logic [1:0] OP_COUNT_WORD   = 2'd1;
    localparam logic [1:0] OP_COUNT_PREFIX = 2'd2;
    localparam logic [1:0] OP_ERASE        = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_MISSING   = 2'd2;

    typedef struct packed {
        logic inc;
        logic dec;
    } cte_cnt_cmd_t;

endpackage

// ----- rtl/counting_trie_engine_unit.sv -----
// Top level of the counting trie engine: sequencer, child table and count memories.
// Depends on cte_pkg and cte_count_unit.
//
// Usage: one letter of a word is presented per beat on operation, letter and
// last_letter; the beat is taken at a rising edge with start high and busy low.
// Insert allocates missing nodes and bumps prefix counts, then the word count
// at the last letter; the two queries report a word or prefix count; erase
// lowers the same counts without going below zero.
// Only a beat with last_letter high yields a result: done is high for one cycle
// and count and status hold the result until the next; the receiver cannot stall.
// A letter on an existing or newly allocated path passes through S_CHILD,
// S_UPDATE and S_FINISH before the next possible accept, with done rising as a
// last letter leaves S_FINISH; this is set by the dependent child-table read, the
// count read and the count update through the one shared count unit. A letter
// that meets a missing branch skips S_UPDATE, and a letter after a missing
// branch goes straight to S_FINISH. In every case done rises at the edge where
// busy drops. After reset the block clears the child table and both count
// memories, one entry a cycle over all NODE_COUNT*ALPHABET_SIZE slots (106496 at
// the default size), and holds busy high until the pass is done.
module counting_trie_engine_unit
    import cte_pkg::*;
#(
    parameter int NODE_COUNT    = CTE_NODE_COUNT,
    parameter int ALPHABET_SIZE = CTE_ALPHABET_SIZE,
    parameter int COUNT_BITS    = CTE_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  operation,
    input  logic [4:0]  letter,
    input  logic        last_letter,
    output logic        busy,
    output logic        done,
    output logic [15:0] count,
    output logic [1:0]  status
);

    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int SYM_BITS   = $clog2(ALPHABET_SIZE);
    localparam int SLOT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_BITS  = $clog2(SLOT_DEPTH);

    localparam logic [SLOT_BITS-1:0] SLOT_LAST  = SLOT_BITS'(SLOT_DEPTH - 1);
    localparam logic [NODE_BITS:0]   FREE_LIMIT = (NODE_BITS + 1)'(NODE_COUNT);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHILD  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    function automatic logic [SYM_BITS-1:0] letter_mod(input logic [4:0] l);
        logic [9:0] rem;
        rem = '0;
        for (int i = 4; i >= 0; i--)
        begin
            rem = {rem[8:0], l[i]};
            if (rem >= 10'(ALPHABET_SIZE))
            begin
                rem = rem - 10'(ALPHABET_SIZE);
            end
        end
        return SYM_BITS'(rem);
    endfunction

    logic [NODE_BITS-1:0]  child_mem  [SLOT_DEPTH];
    logic [COUNT_BITS-1:0] prefix_mem [NODE_COUNT];
    logic [COUNT_BITS-1:0] word_mem   [NODE_COUNT];

    logic [2:0]            state_reg,     state_next;
    logic [SLOT_BITS-1:0]  clr_reg,       clr_next;
    logic [1:0]            op_reg,        op_next;
    logic                  last_reg,      last_next;
    logic [SLOT_BITS-1:0]  slot_reg,      slot_next;
    logic [NODE_BITS-1:0]  cursor_reg,    cursor_next;
    logic [NODE_BITS:0]    next_free_reg, next_free_next;
    logic                  missed_reg,    missed_next;
    logic                  done_reg,      done_next;
    logic [15:0]           count_reg,     count_next;
    logic [1:0]            status_reg,    status_next;

    logic [NODE_BITS-1:0]  child_rd_reg;
    logic [COUNT_BITS-1:0] prefix_rd_reg;
    logic [COUNT_BITS-1:0] word_rd_reg;

    logic                  child_re;
    logic                  child_we;
    logic [SLOT_BITS-1:0]  child_waddr;
    logic [NODE_BITS-1:0]  child_wdata;
    logic                  cnt_re;
    logic [NODE_BITS-1:0]  cnt_raddr;
    logic                  prefix_we;
    logic                  word_we;
    logic [NODE_BITS-1:0]  cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [NODE_BITS-1:0]  target;

    cte_cnt_cmd_t          unit_cmd;
    logic [COUNT_BITS-1:0] unit_value;
    logic [COUNT_BITS-1:0] unit_result;
    logic [31:0]           word_wide;
    logic [31:0]           prefix_wide;

    assign unit_cmd.inc = (op_reg == OP_INSERT);
    assign unit_cmd.dec = (op_reg == OP_ERASE);
    assign unit_value   = (state_reg == S_FINISH) ? word_rd_reg : prefix_rd_reg;
    assign word_wide    = 32'(word_rd_reg);
    assign prefix_wide  = 32'(prefix_rd_reg);

    cte_count_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count_unit (
        .cmd    (unit_cmd),
        .value  (unit_value),
        .result (unit_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        cursor_next    = cursor_reg;
        next_free_next = next_free_reg;
        missed_next    = missed_reg;
        done_next      = 1'b0;
        count_next     = count_reg;
        status_next    = status_reg;
        child_re       = 1'b0;
        child_we       = 1'b0;
        child_waddr    = slot_reg;
        child_wdata    = '0;
        cnt_re         = 1'b0;
        cnt_raddr      = cursor_reg;
        prefix_we      = 1'b0;
        word_we        = 1'b0;
        cnt_waddr      = cursor_reg;
        cnt_wdata      = unit_result;
        target         = child_rd_reg;

        case (state_reg)
            S_CLEAR:
            begin
                child_we    = 1'b1;
                child_waddr = clr_reg;
                child_wdata = '0;
                if (32'(clr_reg) < NODE_COUNT)
                begin
                    prefix_we = 1'b1;
                    word_we   = 1'b1;
                    cnt_waddr = NODE_BITS'(clr_reg);
                    cnt_wdata = '0;
                end
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + SLOT_BITS'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = operation;
                    last_next = last_letter;
                    slot_next = SLOT_BITS'(32'(cursor_reg) * 32'(ALPHABET_SIZE)
                                           + 32'(letter_mod(letter)));
                    child_re  = !missed_reg;
                    state_next = missed_reg ? S_FINISH : S_CHILD;
                end
            end
            S_CHILD:
            begin
                state_next = S_UPDATE;
                if (child_rd_reg == '0)
                begin
                    if (op_reg == OP_INSERT && next_free_reg < FREE_LIMIT)
                    begin
                        target         = NODE_BITS'(next_free_reg);
                        child_we       = 1'b1;
                        child_waddr    = slot_reg;
                        child_wdata    = target;
                        next_free_next = next_free_reg + (NODE_BITS + 1)'(1);
                    end
                    else
                    begin
                        missed_next = 1'b1;
                        state_next  = S_FINISH;
                    end
                end
                if (state_next == S_UPDATE)
                begin
                    cursor_next = target;
                    cnt_re      = 1'b1;
                    cnt_raddr   = target;
                end
            end
            S_UPDATE:
            begin
                if (op_reg == OP_INSERT || op_reg == OP_ERASE)
                begin
                    prefix_we = 1'b1;
                    cnt_waddr = cursor_reg;
                    cnt_wdata = unit_result;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
                if (last_reg)
                begin
                    done_next   = 1'b1;
                    cursor_next = '0;
                    missed_next = 1'b0;
                    count_next  = '0;
                    status_next = ST_OK;
                    if (missed_reg)
                    begin
                        status_next = (op_reg == OP_INSERT) ? ST_POOL_FULL : ST_MISSING;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_COUNT_WORD:   count_next = word_wide[15:0];
                            OP_COUNT_PREFIX: count_next = prefix_wide[15:0];
                            default:
                            begin
                                word_we   = 1'b1;
                                cnt_waddr = cursor_reg;
                                cnt_wdata = unit_result;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            op_reg        <= OP_INSERT;
            last_reg      <= 1'b0;
            slot_reg      <= '0;
            cursor_reg    <= '0;
            next_free_reg <= (NODE_BITS + 1)'(1);
            missed_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            slot_reg      <= slot_next;
            cursor_reg    <= cursor_next;
            next_free_reg <= next_free_next;
            missed_reg    <= missed_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (child_re)
        begin
            child_rd_reg <= child_mem[slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prefix_we)
        begin
            prefix_mem[cnt_waddr] <= cnt_wdata;
        end
        if (word_we)
        begin
            word_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            prefix_rd_reg <= prefix_mem[cnt_raddr];
            word_rd_reg   <= word_mem[cnt_raddr];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign count  = count_reg;
    assign status = status_reg;

endmodule

// ----- rtl/cte_count_unit.sv -----
// Shared count unit of the counting trie engine: saturating increment and
// decrement that stops at zero. Depends on cte_pkg.
module cte_count_unit
    import cte_pkg::*;
#(
    parameter int COUNT_BITS = CTE_COUNT_BITS
)
(
    input  cte_cnt_cmd_t          cmd,
    input  logic [COUNT_BITS-1:0] value,
    output logic [COUNT_BITS-1:0] result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    always_comb
    begin
        result = value;
        if (cmd.inc)
        begin
            if (value != COUNT_MAX)
            begin
                result = value + COUNT_BITS'(1);
            end
        end
        else if (cmd.dec)
        begin
            if (value != '0)
            begin
                result = value - COUNT_BITS'(1);
            end
        end
    end

endmodule
